FILE: src/trial_division_primality_test_defines.svh
// Assertion macros shared by the trial division primality test RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define TDP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tdp assertion failed");
// Checked on every rising edge, reset included.
`define TDP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tdp assertion failed");
`else
`define TDP_ASSERT(lbl, clk, rstn, prop)
`define TDP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: src/tdp_pkg.sv
// Shared types and constants for the trial division primality test.
// No dependencies.
package tdp_pkg;

    // Default datapath width of the tested number.
    localparam int NUMBER_WIDTH_DEF = 16;

    // Status from the remainder unit back to the sequencer.
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder is final
        logic zero;   // remainder is zero, valid with done
    } t_rem_stat;

endpackage

FILE: src/tdp_rem.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// Depends on tdp_pkg and trial_division_primality_test_defines.svh.
`include "trial_division_primality_test_defines.svh"

module tdp_rem #(
    parameter int NUMBER_WIDTH = tdp_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUMBER_WIDTH-1:0] i_dividend,
    input  logic [NUMBER_WIDTH-1:0] i_divisor,
    output tdp_pkg::t_rem_stat      o_stat
);
    import tdp_pkg::*;

    localparam int CW = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;
    localparam logic [CW-1:0] LAST = CW'(NUMBER_WIDTH - 1);

    logic [NUMBER_WIDTH-1:0] r_shift;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [NUMBER_WIDTH:0]   n_trial;
    logic [NUMBER_WIDTH:0]   n_diff;
    logic [NUMBER_WIDTH-1:0] n_rem;

    // partial remainder with the next dividend bit shifted in
    assign n_trial = {r_rem, r_shift[NUMBER_WIDTH-1]};
    assign n_diff  = n_trial - {1'b0, i_divisor};
    assign n_rem   = n_diff[NUMBER_WIDTH] ? n_trial[NUMBER_WIDTH-1:0]
                                          : n_diff[NUMBER_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // pulse after the last bit step
            r_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_shift <= i_dividend;
                r_rem   <= '0;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_shift <= {r_shift[NUMBER_WIDTH-2:0], 1'b0};
                r_rem   <= n_rem;
                r_cnt   <= r_cnt + CW'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

    `TDP_ASSERT(a_start_busy, i_clk, i_rst_n, i_start |=> r_busy)
    `TDP_ASSERT(a_done_idle, i_clk, i_rst_n, r_done |-> !r_busy)
    `TDP_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy))
    `TDP_ASSERT(a_cnt_range, i_clk, i_rst_n, r_busy |-> (r_cnt <= LAST))

endmodule

FILE: src/trial_division_primality_test.sv
// Trial division primality test. Each request carries one unsigned number
// (NUMBER_WIDTH bits) and returns one bit, is_prime; 0 and 1 are not prime.
// Divisors d = 2, 3, ... are tried while d*d <= number; the square is kept
// incrementally ((d+1)^2 = d^2 + 2d + 1), and each divisor runs through a
// bit-serial remainder unit that works one bit per cycle. One request is
// worked at a time; at most floor(sqrt(number)) - 1 divisors are tried.
// A finished result sits in an output register, so a new request is taken
// while the previous result is still stalled downstream.
// Depends on tdp_pkg, tdp_rem and trial_division_primality_test_defines.svh.
`include "trial_division_primality_test_defines.svh"

module trial_division_primality_test #(
    parameter int NUMBER_WIDTH = tdp_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request side
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    // result side
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_is_prime
);
    import tdp_pkg::*;

    localparam int SW = NUMBER_WIDTH + 1;   // square never passes n + 2d + 1

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [NUMBER_WIDTH-1:0] r_num;
    logic [NUMBER_WIDTH-1:0] r_d;
    logic [SW-1:0]           r_sq;
    logic                    r_res;
    logic                    r_out_valid;
    logic                    r_is_prime;

    logic                    n_in_take;
    logic                    n_out_take;
    logic                    n_sq_le;
    logic                    n_start;
    logic [SW-1:0]           n_sq;
    t_rem_stat               rem_stat;

    assign n_in_take  = i_valid && (r_state == S_IDLE);
    assign n_out_take = r_out_valid && !i_stall;
    assign n_sq_le    = (r_sq <= {1'b0, r_num});
    assign n_start    = (r_state == S_CHECK) && n_sq_le;
    // (d+1)^2 from d^2
    assign n_sq       = r_sq + {r_d, 1'b0} + SW'(1);

    tdp_rem #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_start),
        .i_dividend (r_num),
        .i_divisor  (r_d),
        .o_stat     (rem_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in S_OUT a taken result is replaced by the new one below
            if (n_out_take && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_in_take) begin
                        r_num   <= i_number;
                        r_d     <= NUMBER_WIDTH'(2);
                        r_sq    <= SW'(4);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // no divisor left: prime unless the number is 0 or 1
                    if (!n_sq_le) begin
                        r_res   <= (r_num > NUMBER_WIDTH'(1));
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_stat.done) begin
                        if (rem_stat.zero) begin
                            r_res   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_d     <= r_d + NUMBER_WIDTH'(1);
                            r_sq    <= n_sq;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_OUT: begin
                    // move into the output register once it is free
                    if (!r_out_valid || n_out_take) begin
                        r_out_valid <= 1'b1;
                        r_is_prime  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_is_prime;

    `TDP_ASSERT(a_div_in_bound, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (r_sq <= {1'b0, r_num}))
    `TDP_ASSERT(a_divisor_min, i_clk, i_rst_n,
        (r_state == S_CHECK || r_state == S_DIV) |-> (r_d >= NUMBER_WIDTH'(2)))
    `TDP_ASSERT(a_rem_done_in_div, i_clk, i_rst_n,
        rem_stat.done |-> (r_state == S_DIV))
    `TDP_ASSERT(a_load_from_out, i_clk, i_rst_n,
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for trial_division_primality_test: queued requests, random gaps
// and stalls, and a trial-division predictor. Depends on tdp_pkg and the block's RTL.
module tb_top;

    localparam int NW         = tdp_pkg::NUMBER_WIDTH_DEF;
    localparam int N_RANDOM   = 120;
    // Longest correct wait with nothing accepted: a 16-bit prime near the top of the
    // range, plus a long downstream stall. Several times that.
    localparam int IDLE_LIMIT = 40000;
    localparam int TAIL_CYCLES = 64;

    // One expected result, tagged with the number that produced it.
    typedef struct packed {
        logic [NW-1:0] number;
        logic          is_prime;
    } t_verdict;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_valid    = 1'b0;
    logic [NW-1:0] i_number   = '0;
    logic          i_stall    = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic          o_is_prime;

    logic [NW-1:0] number_q[$];    // requests waiting to be driven
    t_verdict      verdict_q[$];   // expected answers, oldest first
    logic          req_taken = 1'b0;

    int n_fail = 0;
    int n_req = 0;
    int n_prime = 0;
    int n_checked = 0;
    int idle_cycles = 0;
    logic [NW-1:0] max_number = '0;

    // driver and receiver pacing
    int gap_left = 0;
    int gap_calm = 0;
    int gap_roll;
    int hold_left = 0;
    int stall_calm = 0;
    int stall_roll;

    trial_division_primality_test #(.NUMBER_WIDTH(NW)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_prime (o_is_prime)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor: exact trial division, d*d <= n, and 0 and 1 are not prime.
    function automatic logic prime_verdict(logic [NW-1:0] n);
        longint unsigned v;
        longint unsigned d;
        v = 64'(n);
        if (v < 2) return 1'b0;
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Smallest prime at or above the start; callers keep it at or below 65521.
    function automatic logic [NW-1:0] prime_from(int unsigned start);
        logic [NW-1:0] n;
        n = NW'(start);
        while (!prime_verdict(n)) n++;
        return n;
    endfunction

    // Random request mix: mostly cheap values, plus values that make the
    // block run its divisor loop deep (semiprimes, primes).
    function automatic logic [NW-1:0] random_number();
        int unsigned sel;
        logic [NW-1:0] p;
        logic [NW-1:0] q;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            return NW'($urandom_range(0, 1023));
        end else if (sel < 75) begin
            return NW'($urandom());                  // full width, every bit toggles
        end else if (sel < 88) begin
            p = prime_from($urandom_range(2, 251));  // product of two primes <= 251
            q = prime_from($urandom_range(2, 251));
            return p * q;
        end else if (sel < 95) begin
            return prime_from($urandom_range(2, 4093));
        end else begin
            return prime_from($urandom_range(40000, 65521));
        end
    endfunction

    // Sender pauses until the block has nothing queued, in flight or owed.
    task automatic wait_drained();
        @(posedge i_clk);
        #1;
        while (number_q.size() != 0 || i_valid || verdict_q.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // Request driver. Valid and payload move only at the falling edge and
    // only once the current request was taken, so a stalled request holds.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_number <= '0;
        end else if (!i_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_valid <= 1'b0;
            end else if (number_q.size() != 0) begin
                i_valid  <= 1'b1;
                i_number <= number_q.pop_front();
                // gap before the next request: calm runs, mostly short, rarely long
                gap_roll = $urandom_range(0, 99);
                if (gap_calm > 0) begin
                    gap_calm = gap_calm - 1;
                    gap_left = 0;
                end else if (gap_roll < 5) begin
                    gap_calm = $urandom_range(8, 24);
                    gap_left = 0;
                end else if (gap_roll < 50) begin
                    gap_left = 0;
                end else if (gap_roll < 85) begin
                    gap_left = $urandom_range(1, 3);
                end else if (gap_roll < 97) begin
                    gap_left = $urandom_range(4, 20);
                end else begin
                    gap_left = $urandom_range(50, 300);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure, independent of o_valid so stalls land on
    // every phase of the block's work.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
        end else if (stall_calm > 0) begin
            stall_calm = stall_calm - 1;
            i_stall <= 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 4) begin
                stall_calm = $urandom_range(30, 120);
                i_stall <= 1'b0;
            end else if (stall_roll < 55) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b1;
                if (stall_roll < 85)      hold_left = $urandom_range(0, 2);
                else if (stall_roll < 97) hold_left = $urandom_range(3, 20);
                else                      hold_left = $urandom_range(40, 250);
            end
        end
    end

    // Monitor: record each accepted request's expected answer, check each
    // accepted result against the oldest one.
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                want.number   = i_number;
                want.is_prime = prime_verdict(i_number);
                verdict_q = {verdict_q, want};
                n_req++;
                if (want.is_prime) n_prime++;
                if (i_number > max_number) max_number = i_number;
            end
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got is_prime=%0b",
                             $time, o_is_prime);
                    n_fail++;
                end else begin
                    want = verdict_q.pop_front();
                    n_checked++;
                    if (o_is_prime !== want.is_prime) begin
                        $display("%0t: is_prime mismatch for %0d: expected %0b, got %0b",
                                 $time, want.number, want.is_prime, o_is_prime);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Watchdog: too long with no request and no result accepted.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, verdict_q.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Directed: 0 and 1 (not prime), 2 and 3 (no divisor tried), small
        // squares, primes of the form 2^k - 1, bit patterns, the square of the
        // largest prime below 256 (slowest composite), the largest 16-bit
        // prime (slowest overall) and all-ones.
        number_q = '{0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 127, 8191, 32749, 32768,
                     21845, 43690, 63001, 64507, 65521, 65535};

        // synchronous reset, released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pause the sender until every directed answer is back
        wait_drained();

        for (int k = 0; k < N_RANDOM; k++) begin
            number_q = {number_q, random_number()};
            if (k == N_RANDOM / 2) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d requests: %0d prime, largest number %0d.",
                 n_checked, n_req, n_prime, max_number);
        $display("Mix: edge values, small and full-width values, semiprimes, large primes.");
        if (n_fail == 0 && verdict_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures, %0d results never arrived", n_fail, verdict_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
